[hw/rtl/clmph_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clmph_pkg: shared types and constants of the channel level meter
// Register codes, reset values, fixed-point constants, the per-channel meter
// entry and the controller command bundle.
// ----------------------------------------------------------------------------
package clmph_pkg;

    // Fixed field widths
    localparam int CHAN_W     = 4;
    localparam int CHAN_CODES = 1 << CHAN_W;
    localparam int LVL_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 16;

    // Configuration register codes
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_MS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY_RATE = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_GRACE_MS        = 16'd200;
    localparam logic [CFG_W-1:0] RST_ATTACK_RATE     = 16'd230;
    localparam logic [CFG_W-1:0] RST_DECAY_RATE      = 16'd15;
    localparam logic [CFG_W-1:0] RST_PEAK_HOLD_MS    = 16'd800;
    localparam logic [CFG_W-1:0] RST_PEAK_DECAY_RATE = 16'd8;

    // Level arithmetic
    localparam logic [LVL_W-1:0] FULL_SCALE  = 15'd25600;
    localparam logic [15:0]      SAT16       = 16'hFFFF;
    localparam logic [6:0]       VOL_FULL    = 7'd127;
    localparam logic [5:0]       BOOST_MAX   = 6'd40;
    localparam logic [5:0]       BOOST_OFS   = 6'd23;   // 25 - 2 for one voice
    localparam logic [7:0]       BOOST_KNEE  = 8'd9;    // voice count that hits the cap
    // x * 1024 / 16129 by reciprocal: M = floor(2^34 / 16129), shift 24
    localparam logic [20:0]      RECIP_M     = 21'd1065154;
    localparam int               RECIP_SHIFT = 24;
    localparam logic [13:0]      DIV_K       = 14'd16129;
    // Smallest product whose scaled value reaches full scale
    localparam logic [19:0]      CLAMP_X     = 20'd403225;

    typedef struct packed {
        logic [CFG_W-1:0] grace_ms;
        logic [CFG_W-1:0] attack_rate;
        logic [CFG_W-1:0] decay_rate;
        logic [CFG_W-1:0] peak_hold_ms;
        logic [CFG_W-1:0] peak_decay_rate;
    } cfg_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] peak;
        logic [15:0]      age;
        logic [31:0]      last_update;
        logic [31:0]      last_sound;
        logic             sounded;
    } entry_t;

    typedef struct packed {
        logic load;    // take the input word
        logic read;    // read the channel entry
        logic calc;    // elapsed time, grace test, quotient estimate
        logic corr;    // quotient check product, peak step
        logic tgt;     // target level
        logic step;    // level step
        logic lvl;     // new level
        logic wb;      // peak, write back, load result
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/clmph_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clmph_regs: configuration register bank
// Holds the five meter settings; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module clmph_regs import clmph_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grace_ms        <= RST_GRACE_MS;
            cfg_reg.attack_rate     <= RST_ATTACK_RATE;
            cfg_reg.decay_rate      <= RST_DECAY_RATE;
            cfg_reg.peak_hold_ms    <= RST_PEAK_HOLD_MS;
            cfg_reg.peak_decay_rate <= RST_PEAK_DECAY_RATE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRACE_MS:        cfg_reg.grace_ms        <= cfg_data;
                REG_ATTACK_RATE:     cfg_reg.attack_rate     <= cfg_data;
                REG_DECAY_RATE:      cfg_reg.decay_rate      <= cfg_data;
                REG_PEAK_HOLD_MS:    cfg_reg.peak_hold_ms    <= cfg_data;
                REG_PEAK_DECAY_RATE: cfg_reg.peak_decay_rate <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/clmph_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clmph_ctrl: sequencing state machine
// Steps one word through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module clmph_ctrl import clmph_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_CORR,
        ST_TGT,
        ST_STEP,
        ST_LVL,
        ST_WB
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    always_comb begin
        cmd      = '0;
        cmd.load = (state_reg == ST_IDLE) && s_valid;
        cmd.read = (state_reg == ST_READ);
        cmd.calc = (state_reg == ST_CALC);
        cmd.corr = (state_reg == ST_CORR);
        cmd.tgt  = (state_reg == ST_TGT);
        cmd.step = (state_reg == ST_STEP);
        cmd.lvl  = (state_reg == ST_LVL);
        cmd.wb   = (state_reg == ST_WB) && slot_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Load a new result, or drop the one just taken
            if ((state_reg == ST_WB) && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_CALC;
                ST_CALC: state_reg <= ST_CORR;
                ST_CORR: state_reg <= ST_TGT;
                ST_TGT:  state_reg <= ST_STEP;
                ST_STEP: state_reg <= ST_LVL;
                ST_LVL:  state_reg <= ST_WB;
                ST_WB: begin
                    if (slot_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/clmph_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clmph_dp: meter datapath
// Per-channel entry memory with valid bits, target level, ballistics and
// peak hold, and the result word register.
// ----------------------------------------------------------------------------
module clmph_dp import clmph_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    input  wire cfg_t              cfg,
    input  wire logic [CHAN_W-1:0] s_channel,
    input  wire logic [31:0]       s_now_ms,
    input  wire logic [6:0]        s_volume,
    input  wire logic              s_volume_known,
    input  wire logic [6:0]        s_velocity,
    input  wire logic [7:0]        s_voice_count,
    output logic [CHAN_W-1:0]      m_out_channel,
    output logic [LVL_W-1:0]       m_level,
    output logic [LVL_W-1:0]       m_peak
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Channel code to store row (code modulo CHANNELS), constant table
    logic [IDX_W-1:0] chan_map [CHAN_CODES];
    for (genvar i = 0; i < CHAN_CODES; i++) begin : g_map
        assign chan_map[i] = IDX_W'(i % CHANNELS);
    end

    entry_t               meter_mem [CHANNELS];
    logic [CHANNELS-1:0]  valid_reg;

    logic [CHAN_W-1:0]    chan_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [31:0]          now_reg;
    logic [7:0]           voices_reg;
    logic [13:0]          vv_reg;
    logic [5:0]           boost_reg;
    entry_t               rd_reg;
    logic                 hit_reg;
    logic [19:0]          x_reg;
    logic [15:0]          dt_reg;
    logic                 ring_reg;
    logic [16:0]          qe_reg;
    logic [30:0]          qm_reg;
    logic [31:0]          pstep_reg;
    logic [LVL_W-1:0]     target_reg;
    logic [31:0]          lstep_reg;
    logic                 rise_reg;
    logic [LVL_W-1:0]     lvl_reg;
    logic [CHAN_W-1:0]    out_chan_reg;
    logic [LVL_W-1:0]     out_level_reg;
    logic [LVL_W-1:0]     out_peak_reg;

    entry_t               entry;
    logic [6:0]           vol_eff;
    logic [5:0]           boost_next;
    logic [31:0]          dt_diff;
    logic [15:0]          dt_next;
    logic [31:0]          snd_diff;
    logic                 ring_next;
    logic [40:0]          prod_m;
    logic [30:0]          x1024;
    logic                 bump;
    logic [LVL_W-1:0]     target_next;
    logic                 rise_next;
    logic [15:0]          rate_sel;
    logic [32:0]          up_sum;
    logic [32:0]          down_floor;
    logic [LVL_W-1:0]     lvl_next;
    logic [16:0]          age_sum;
    logic [15:0]          age_sat;
    logic [32:0]          pk_floor;
    logic [LVL_W-1:0]     pk_next;
    logic [15:0]          age_next;
    logic                 sounding;
    entry_t               wr_entry;

    assign entry    = hit_reg ? rd_reg : '0;
    assign sounding = (voices_reg != 8'd0);

    // Input word: effective volume, velocity product and voice boost
    always_comb begin
        vol_eff = s_volume_known ? s_volume : VOL_FULL;
        if (s_voice_count >= BOOST_KNEE) begin
            boost_next = BOOST_MAX;
        end else begin
            boost_next = BOOST_OFS + 6'({s_voice_count[3:0], 1'b0});
        end
    end

    // Elapsed time, grace test, quotient estimate
    always_comb begin
        dt_diff = now_reg - entry.last_update;
        if (!hit_reg || (now_reg < entry.last_update)) begin
            dt_next = 16'd0;
        end else if (dt_diff[31:16] != 16'd0) begin
            dt_next = SAT16;
        end else begin
            dt_next = dt_diff[15:0];
        end
        snd_diff  = (now_reg >= entry.last_sound) ? (now_reg - entry.last_sound) : 32'd0;
        ring_next = entry.sounded && (snd_diff < {16'd0, cfg.grace_ms});
        prod_m    = 41'(x_reg) * 41'(RECIP_M);
    end

    // Target: estimate is at most one short, fix with one compare
    always_comb begin
        x1024 = {1'b0, x_reg, 10'd0};
        bump  = (x1024 >= (qm_reg + 31'(DIV_K)));
        if (sounding) begin
            if (x_reg >= CLAMP_X) begin
                target_next = FULL_SCALE;
            end else begin
                target_next = LVL_W'(qe_reg + 17'(bump));
            end
        end else if (ring_reg) begin
            target_next = entry.level;
        end else begin
            target_next = '0;
        end
        rise_next = (target_reg > entry.level);
        rate_sel  = rise_next ? cfg.attack_rate : cfg.decay_rate;
    end

    // Move level toward target by the step
    always_comb begin
        up_sum     = 33'(entry.level) + 33'(lstep_reg);
        down_floor = 33'(lstep_reg) + 33'(target_reg);
        if (rise_reg) begin
            lvl_next = (up_sum >= 33'(target_reg)) ? target_reg : up_sum[LVL_W-1:0];
        end else if (down_floor > 33'(entry.level)) begin
            lvl_next = target_reg;
        end else begin
            lvl_next = entry.level - lstep_reg[LVL_W-1:0];
        end
    end

    // Peak hold and decay, never below the level
    always_comb begin
        age_sum  = 17'(entry.age) + 17'(dt_reg);
        age_sat  = age_sum[16] ? SAT16 : age_sum[15:0];
        pk_floor = 33'(pstep_reg) + 33'(lvl_reg);
        if (lvl_reg >= entry.peak) begin
            pk_next  = lvl_reg;
            age_next = 16'd0;
        end else begin
            age_next = age_sat;
            if (age_sat > cfg.peak_hold_ms) begin
                if (pk_floor > 33'(entry.peak)) begin
                    pk_next = lvl_reg;
                end else begin
                    pk_next = entry.peak - pstep_reg[LVL_W-1:0];
                end
            end else begin
                pk_next = entry.peak;
            end
        end
        wr_entry.level       = lvl_reg;
        wr_entry.peak        = pk_next;
        wr_entry.age         = age_next;
        wr_entry.last_update = now_reg;
        wr_entry.last_sound  = sounding ? now_reg : entry.last_sound;
        wr_entry.sounded     = entry.sounded || sounding;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            chan_reg   <= s_channel;
            idx_reg    <= chan_map[s_channel];
            now_reg    <= s_now_ms;
            voices_reg <= s_voice_count;
            vv_reg     <= 14'(vol_eff) * 14'(s_velocity);
            boost_reg  <= boost_next;
        end
        if (cmd.read) begin
            rd_reg  <= meter_mem[idx_reg];
            hit_reg <= valid_reg[idx_reg];
            x_reg   <= 20'(vv_reg) * 20'(boost_reg);
        end
        if (cmd.calc) begin
            dt_reg   <= dt_next;
            ring_reg <= ring_next;
            qe_reg   <= prod_m[RECIP_SHIFT+16:RECIP_SHIFT];
        end
        if (cmd.corr) begin
            qm_reg    <= 31'(qe_reg) * 31'(DIV_K);
            pstep_reg <= 32'(cfg.peak_decay_rate) * 32'(dt_reg);
        end
        if (cmd.tgt) begin
            target_reg <= target_next;
        end
        if (cmd.step) begin
            rise_reg  <= rise_next;
            lstep_reg <= 32'(rate_sel) * 32'(dt_reg);
        end
        if (cmd.lvl) begin
            lvl_reg <= lvl_next;
        end
        if (cmd.wb) begin
            meter_mem[idx_reg] <= wr_entry;
            out_chan_reg       <= chan_reg;
            out_level_reg      <= lvl_reg;
            out_peak_reg       <= pk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.wb) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    assign m_out_channel = out_chan_reg;
    assign m_level       = out_level_reg;
    assign m_peak        = out_peak_reg;

endmodule

`default_nettype wire

[hw/rtl/channel_level_meter_peak_hold.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// channel_level_meter_peak_hold: per-channel level meter with peak hold
// Each input word is a channel snapshot; each result word carries the new
// meter level and peak marker of that channel, Q8 percent.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     s_valid / s_ready    s_channel, s_now_ms, s_volume,
//                                 s_volume_known, s_velocity, s_voice_count
//  result    m_valid / m_ready    m_out_channel, m_level, m_peak
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  A word is taken in idle and walks the read, elapsed time, quotient check,
//  target, step, level and write-back states; the result register loads as
//  the word leaves write-back, and only then is the next word taken, so the
//  block takes no new word before it is through with the last one.
//  Reset clears the channel valid bits at once; every channel then reads as
//  silent with zero level, peak and age. No clearing pass is needed.
//  A result held by m_ready low does not block the next input word; that
//  word waits in write-back until the result register frees up.
// ----------------------------------------------------------------------------
module channel_level_meter_peak_hold import clmph_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input snapshot channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CHAN_W-1:0]    s_channel,
    input  wire logic [31:0]          s_now_ms,
    input  wire logic [6:0]           s_volume,
    input  wire logic                 s_volume_known,
    input  wire logic [6:0]           s_velocity,
    input  wire logic [7:0]           s_voice_count,
    // Result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CHAN_W-1:0]         m_out_channel,
    output logic [LVL_W-1:0]          m_level,
    output logic [LVL_W-1:0]          m_peak,
    // Configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    cfg_t cfg;
    cmd_t cmd;

    // Settings: grace window, attack/decay rates, peak hold and decay
    clmph_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: one word at a time, owns s_ready and m_valid
    clmph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath: entry memory, target, ballistics, peak hold, result register
    clmph_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg            (cfg),
        .s_channel      (s_channel),
        .s_now_ms       (s_now_ms),
        .s_volume       (s_volume),
        .s_volume_known (s_volume_known),
        .s_velocity     (s_velocity),
        .s_voice_count  (s_voice_count),
        .m_out_channel  (m_out_channel),
        .m_level        (m_level),
        .m_peak         (m_peak)
    );

    // Busy after an accept: the next word waits for this one to finish
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in flight");

    // Peak marker never sits below the level, level never above full scale
    a_peak_over_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_peak >= m_level) && (m_level <= FULL_SCALE))
        else $error("peak below level or level over full scale");

    // A result never appears in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result produced without the full update sequence");

endmodule

`default_nettype wire

[sim/channel_level_meter_peak_hold_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_level_meter_peak_hold_test: self-checking bench of the level meter
// Drives channel snapshots into the meter and compares every result word with
// an in-bench model of the per-channel level ballistics and peak marker. A
// short directed table runs first, then randomized phases, each under its own
// register setting, sender burst pattern and receiver stall pattern.
// ----------------------------------------------------------------------------
module channel_level_meter_peak_hold_test;
    import clmph_pkg::*;

    localparam int CHANNELS      = 16;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 16;     // settle wait after the last reading is back
    localparam int QUIET_LIMIT   = 4000;   // cycles with no word moved on any channel
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_REGS      = 5;
    localparam int PHASES        = 7;
    localparam int PHASE_WORDS   = 275;

    // Target arithmetic: boost in units of 1/25, two units per voice, product scaled by 1024 / 127^2
    localparam longint unsigned BOOST_BASE = 25;
    localparam longint unsigned BOOST_STEP = 2;
    localparam longint unsigned TGT_SCALE  = 1024;

    typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_STRETCH} sink_mode_t;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [31:0]       now_ms;
        logic [6:0]        volume;
        logic              volume_known;
        logic [6:0]        velocity;
        logic [7:0]        voice_count;
    } snapshot_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [LVL_W-1:0]  level;
        logic [LVL_W-1:0]  peak;
    } reading_t;

    typedef struct packed {
        snapshot_t        word;
        logic             typed;    // expected reading given in the row itself
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] peak;
    } probe_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CHAN_W-1:0]    s_channel = '0;
    logic [31:0]          s_now_ms = '0;
    logic [6:0]           s_volume = '0;
    logic                 s_volume_known = 1'b0;
    logic [6:0]           s_velocity = '0;
    logic [7:0]           s_voice_count = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b1;
    logic [CHAN_W-1:0]    m_out_channel;
    logic [LVL_W-1:0]     m_level;
    logic [LVL_W-1:0]     m_peak;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    always #(HALF_PERIOD) aclk = ~aclk;

    channel_level_meter_peak_hold #(
        .CHANNELS (CHANNELS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel      (s_channel),
        .s_now_ms       (s_now_ms),
        .s_volume       (s_volume),
        .s_volume_known (s_volume_known),
        .s_velocity     (s_velocity),
        .s_voice_count  (s_voice_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_channel  (m_out_channel),
        .m_level        (m_level),
        .m_peak         (m_peak),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Meter model: register copy and per-channel history
    // ------------------------------------------------------------------------
    cfg_t              meter_cfg = '{RST_GRACE_MS, RST_ATTACK_RATE, RST_DECAY_RATE,
                                     RST_PEAK_HOLD_MS, RST_PEAK_DECAY_RATE};
    logic [LVL_W-1:0]  level_mem   [CHANNELS] = '{default: '0};
    logic [LVL_W-1:0]  peak_mem    [CHANNELS] = '{default: '0};
    logic [15:0]       age_mem     [CHANNELS] = '{default: '0};
    logic [31:0]       update_time [CHANNELS] = '{default: '0};
    logic [31:0]       sound_time  [CHANNELS] = '{default: '0};
    bit                seen        [CHANNELS] = '{default: 1'b0};
    bit                has_sounded [CHANNELS] = '{default: 1'b0};

    reading_t          expected_readings[$];
    probe_row_t        probe_table[$];
    int                mismatches = 0;
    int                quiet_cycles = 0;
    sink_mode_t        sink_mode = SINK_ALWAYS;
    int                stall_left = 0;

    // Time since an earlier stamp; a stamp from the future counts as no time.
    function automatic longint unsigned elapsed_ms(logic [31:0] now, logic [31:0] then_ms);
        return (now >= then_ms) ? longint'(now - then_ms) : 0;
    endfunction

    function automatic longint unsigned clip16(longint unsigned v);
        return (v > SAT16) ? longint'(SAT16) : v;
    endfunction

    // Move cur toward tgt by at most rate * dt, never past it.
    function automatic longint unsigned approach(longint unsigned cur, longint unsigned tgt,
                                                 longint unsigned up, longint unsigned down,
                                                 longint unsigned dt);
        longint unsigned stride;
        if (tgt > cur) begin
            stride = up * dt;
            return (cur + stride >= tgt) ? tgt : cur + stride;
        end
        stride = down * dt;
        return (cur < stride + tgt) ? tgt : cur - stride;
    endfunction

    // Advance the model by one snapshot and return the reading it produces.
    function automatic reading_t next_meter_reading(snapshot_t w);
        int unsigned     c;
        longint unsigned dt;
        longint unsigned target;
        longint unsigned boost;
        longint unsigned vol;
        longint unsigned scaled;
        longint unsigned lvl;
        longint unsigned pk;
        reading_t        r;
        c      = int'(w.channel) % CHANNELS;
        dt     = 0;
        target = 0;
        if (w.voice_count != 0) begin
            sound_time[c]  = w.now_ms;
            has_sounded[c] = 1'b1;
        end
        // First snapshot of a channel sees no elapsed time
        if (seen[c])
            dt = clip16(elapsed_ms(w.now_ms, update_time[c]));
        update_time[c] = w.now_ms;
        seen[c]        = 1'b1;
        vol = w.volume_known ? longint'(w.volume) : longint'(VOL_FULL);
        if (w.voice_count != 0) begin
            boost = BOOST_BASE + BOOST_STEP * (longint'(w.voice_count) - 1);
            if (boost > BOOST_MAX)
                boost = BOOST_MAX;
            scaled = vol * longint'(w.velocity) * boost * TGT_SCALE / longint'(DIV_K);
            target = (scaled > FULL_SCALE) ? longint'(FULL_SCALE) : scaled;
        end else if (has_sounded[c] &&
                     elapsed_ms(w.now_ms, sound_time[c]) < meter_cfg.grace_ms) begin
            // Still ringing after note-off: hold the level
            target = level_mem[c];
        end
        lvl = approach(level_mem[c], target, meter_cfg.attack_rate, meter_cfg.decay_rate, dt);
        level_mem[c] = lvl[LVL_W-1:0];
        pk = peak_mem[c];
        if (lvl >= pk) begin
            pk         = lvl;
            age_mem[c] = '0;
        end else begin
            age_mem[c] = 16'(clip16(longint'(age_mem[c]) + dt));
            if (age_mem[c] > meter_cfg.peak_hold_ms)
                pk = approach(pk, lvl, 0, meter_cfg.peak_decay_rate, dt);
        end
        peak_mem[c] = pk[LVL_W-1:0];
        r.chan  = w.channel;
        r.level = lvl[LVL_W-1:0];
        r.peak  = pk[LVL_W-1:0];
        return r;
    endfunction

    function automatic probe_row_t probe(logic [CHAN_W-1:0] ch, logic [31:0] now,
                                         logic [6:0] vol, logic known, logic [6:0] velo,
                                         logic [7:0] voices, logic typed,
                                         logic [LVL_W-1:0] lvl, logic [LVL_W-1:0] pk);
        probe_row_t row;
        row.word.channel      = ch;
        row.word.now_ms       = now;
        row.word.volume       = vol;
        row.word.volume_known = known;
        row.word.velocity     = velo;
        row.word.voice_count  = voices;
        row.typed             = typed;
        row.level             = lvl;
        row.peak              = pk;
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void add_probe(probe_row_t row);
        probe_table = {probe_table, row};
    endfunction

    // ------------------------------------------------------------------------
    // Sender side: present a word at the falling edge, hold it until taken,
    // then queue its expected reading. Valid stays high for a following word.
    // ------------------------------------------------------------------------
    task automatic send_word(input snapshot_t w, input bit typed, input reading_t typed_r);
        reading_t r;
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_channel      <= w.channel;
        s_now_ms       <= w.now_ms;
        s_volume       <= w.volume;
        s_volume_known <= w.volume_known;
        s_velocity     <= w.velocity;
        s_voice_count  <= w.voice_count;
        do @(posedge aclk); while (s_ready !== 1'b1);
        r = next_meter_reading(w);
        expected_readings = {expected_readings, (typed ? typed_r : r)};
    endtask

    // Write one register and mirror it into the model; unknown indexes are dropped.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_GRACE_MS:        meter_cfg.grace_ms        = data;
            REG_ATTACK_RATE:     meter_cfg.attack_rate     = data;
            REG_DECAY_RATE:      meter_cfg.decay_rate      = data;
            REG_PEAK_HOLD_MS:    meter_cfg.peak_hold_ms    = data;
            REG_PEAK_DECAY_RATE: meter_cfg.peak_decay_rate = data;
            default: ;
        endcase
    endtask

    // Drop valid, wait out every pending reading, then let the pipeline empty.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: stall pattern chosen per phase
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_ALWAYS: begin
                    m_ready <= 1'b1;
                end
                SINK_RANDOM: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    // Long stretches of back-pressure with open windows between
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left <= $urandom_range(1, 30);
                        m_ready    <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each taken word with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word: ch %0d level %0d peak %0d",
                             m_out_channel, m_level, m_peak);
            end else begin
                want = expected_readings.pop_front();
                if (m_out_channel !== want.chan || m_level !== want.level ||
                    m_peak !== want.peak) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp ch %0d lvl %0d pk %0d, got ch %0d lvl %0d pk %0d",
                                 want.chan, want.level, want.peak,
                                 m_out_channel, m_level, m_peak);
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        cfg_t       phase_cfg [PHASES];
        int         phase_gap [PHASES];
        sink_mode_t phase_sink[PHASES];
        snapshot_t  w;
        reading_t   typed_r;
        logic [31:0] clock_ms;
        int         burst_left;
        int         gap;
        int         pick;

        // Hold reset, then release at a falling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Unknown register indexes must leave the setting untouched
        for (int k = NUM_REGS; k < (1 << CFG_IDX_W); k++)
            cfg_write(CFG_IDX_W'(k), SAT16);
        @(negedge aclk);
        cfg_valid <= 1'b0;

        // Directed table under the reset setting
        //              ch  now_ms          vol kn vel voices typed lvl pk
        add_probe(probe(0, 0,            127, 1, 127, 1,   1, 0, 0)); // first snapshot
        add_probe(probe(0, 100,          127, 1, 127, 9,   0, 0, 0)); // boost at cap
        add_probe(probe(0, 200,          127, 1, 127, 255, 0, 0, 0)); // most voices, clamp
        add_probe(probe(0, 250,          127, 1, 127, 0,   0, 0, 0)); // note-off, in grace
        add_probe(probe(0, 750,          0,   1, 0,   0,   0, 0, 0)); // decay, peak held
        add_probe(probe(0, 1250,         0,   1, 0,   0,   0, 0, 0)); // peak starts falling
        add_probe(probe(0, 1000,         0,   1, 0,   0,   0, 0, 0)); // time steps back
        add_probe(probe(0, 101000,       0,   1, 0,   0,   1, 0, 0)); // long gap saturates
        add_probe(probe(15, 32'hFFFF0000, 0,  0, 127, 1,   1, 0, 0)); // volume unknown
        add_probe(probe(15, 32'hFFFFFFFF, 0,  0, 127, 1,   0, 0, 0)); // full scale target
        add_probe(probe(15, 0,           0,   1, 0,   0,   0, 0, 0)); // wrap: backward
        add_probe(probe(7, 10,           1,   1, 1,   1,   1, 0, 0));
        add_probe(probe(7, 20,           1,   1, 1,   1,   0, 0, 0)); // smallest target
        add_probe(probe(7, 30,           127, 1, 0,   3,   0, 0, 0)); // zero velocity
        add_probe(probe(3, 5,            64,  0, 100, 0,   1, 0, 0));
        add_probe(probe(3, 6,            127, 1, 127, 0,   0, 0, 0)); // never sounded
        add_probe(probe(8, 0,            85,  1, 42,  170, 1, 0, 0));
        add_probe(probe(8, 50,           85,  1, 42,  170, 0, 0, 0));
        add_probe(probe(8, 60,           127, 1, 127, 1,   0, 0, 0)); // one voice, full
        add_probe(probe(9, 0,            127, 1, 127, 8,   0, 0, 0)); // one below the cap

        sink_mode = SINK_STRETCH;
        foreach (probe_table[i]) begin
            typed_r.chan  = probe_table[i].word.channel;
            typed_r.level = probe_table[i].level;
            typed_r.peak  = probe_table[i].peak;
            send_word(probe_table[i].word, probe_table[i].typed, typed_r);
        end
        drain_results();

        // Phase settings: extremes, the reset values written back, random ones
        phase_cfg[0] = '{RST_GRACE_MS, RST_ATTACK_RATE, RST_DECAY_RATE,
                         RST_PEAK_HOLD_MS, RST_PEAK_DECAY_RATE};
        phase_cfg[1] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        phase_cfg[2] = '{SAT16, SAT16, SAT16, SAT16, SAT16};
        phase_cfg[3] = '{16'd0, SAT16, 16'd1, 16'd0, SAT16};
        phase_cfg[4] = '{CFG_W'($urandom_range(0, 1000)), CFG_W'($urandom_range(0, 500)),
                         CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 2000)),
                         CFG_W'($urandom_range(0, 100))};
        phase_cfg[5] = '{CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                         CFG_W'($urandom), CFG_W'($urandom)};
        phase_cfg[6] = '{SAT16, 16'd1, SAT16, SAT16, 16'd1};
        phase_gap  = '{3, 0, 6, 2, 4, 1, 5};
        phase_sink = '{SINK_RANDOM, SINK_ALWAYS, SINK_STRETCH, SINK_RANDOM,
                       SINK_STRETCH, SINK_RANDOM, SINK_STRETCH};

        clock_ms = 32'd2000;
        for (int p = 0; p < PHASES; p++) begin
            // Registers change only with the block idle
            cfg_write(REG_GRACE_MS,        phase_cfg[p].grace_ms);
            cfg_write(REG_ATTACK_RATE,     phase_cfg[p].attack_rate);
            cfg_write(REG_DECAY_RATE,      phase_cfg[p].decay_rate);
            cfg_write(REG_PEAK_HOLD_MS,    phase_cfg[p].peak_hold_ms);
            cfg_write(REG_PEAK_DECAY_RATE, phase_cfg[p].peak_decay_rate);
            @(negedge aclk);
            cfg_valid <= 1'b0;
            sink_mode  = phase_sink[p];
            burst_left = 0;

            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Sender bursts with idle gaps between them
                if (burst_left == 0) begin
                    gap = $urandom_range(0, phase_gap[p]);
                    if (gap != 0) begin
                        @(negedge aclk);
                        s_valid <= 1'b0;
                        repeat (gap - 1) @(negedge aclk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;

                // Advance the shared clock: mostly small steps, some long
                // gaps, some backward steps, now and then a jump anywhere
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    clock_ms = clock_ms + $urandom_range(0, 20);
                else if (pick < 85)
                    clock_ms = clock_ms + $urandom_range(0, 400);
                else if (pick < 92)
                    clock_ms = clock_ms + $urandom_range(500, 5000);
                else if (pick < 95)
                    clock_ms = clock_ms + $urandom_range(65536, 200000);
                else if (pick < 98)
                    clock_ms = clock_ms - $urandom_range(1, 300);
                else
                    clock_ms = $urandom;
                w.now_ms = clock_ms;

                // Favor a few channels so their history runs deep
                w.channel = ($urandom_range(0, 1) == 0) ? CHAN_W'($urandom_range(0, 3))
                                                        : CHAN_W'($urandom_range(0, 15));
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    w.voice_count = '0;
                else if (pick < 85)
                    w.voice_count = 8'($urandom_range(1, 12));
                else
                    w.voice_count = 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                w.volume = (pick == 0) ? VOL_FULL : (pick == 1) ? 7'd0
                                                  : 7'($urandom_range(0, 127));
                pick = $urandom_range(0, 9);
                w.velocity = (pick == 0) ? VOL_FULL : (pick == 1) ? 7'd0
                                                    : 7'($urandom_range(0, 127));
                w.volume_known = ($urandom_range(0, 99) < 85);

                send_word(w, 1'b0, '0);

                // Now and then hold the sender until every reading is back
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
            drain_results();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
